// ===== hw/rtl/htlp_pkg.sv =====
// Package for the linear-probing hash table: field widths, result codes,
// table entry layout, controller states and controller/datapath structs.
// Depends on nothing.
package htlp_pkg;

    localparam int KEY_W    = 14;
    localparam int AGE_W    = 7;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 3;

    // Fraction bits of the reciprocal used to reduce a key modulo the table size.
    localparam int RECIP_SHIFT = 28;

    // Request types.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_HOME     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PROBED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OCCUPIED = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_MUL,
        S_HASH_SUB,
        S_PROBE_START,
        S_PROBE,
        S_READ_ISSUE,
        S_READ_DONE,
        S_FULL
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic probe_start;
        logic probe_step;
        logic probe_place;
        logic read_issue;
        logic read_done;
        logic report_full;
    } t_ctl_cmd;

    typedef struct packed {
        logic full;
        logic clr_last;
        logic slot_free;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/htlp_if.sv =====
// Request and response channel interfaces of the hash table.
// Depends on htlp_pkg.
interface htlp_req_if;
    import htlp_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age_in;
    logic [SLOT_W-1:0] read_slot;

    modport source (output valid, output req_type, output key, output age_in,
                    output read_slot, input ready);
    modport sink   (input valid, input req_type, input key, input age_in,
                    input read_slot, output ready);
endinterface

interface htlp_rsp_if;
    import htlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [KEY_W-1:0]    key_out;
    logic [AGE_W-1:0]    age_out;

    modport source (output valid, output status, output slot_index, output key_out,
                    output age_out, input ready);
    modport sink   (input valid, input status, input slot_index, input key_out,
                    input age_out, output ready);
endinterface

// ===== hw/rtl/hash_table_linear_probe_insert_top.sv =====
// Linear-probing hash table top level; depends on htlp_pkg, htlp_if, htlp_ctrl, htlp_datapath.
// From request to response register, an insert goes through the hash multiply, hash subtract,
// probe start and probe states, a read through read issue and read done, and an insert into a
// full table through the full state; the next request is taken once the controller is idle.
// Throughput is one request at a time; probing visits one slot per cycle on the memory port.
// Synchronous active-low reset clears the table one slot per cycle; no request is taken meanwhile.
module hash_table_linear_probe_insert_top #(
    parameter int TABLE_SIZE = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htlp_req_if.sink    i_req,
    htlp_rsp_if.source  o_rsp
);
    import htlp_pkg::*;

    // The controller only decides; the datapath holds the table, the count
    // and the response register, and reports back through a status struct.
    t_ctl_cmd   cmd;
    t_dp_status dp_status;

    htlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_status    (dp_status),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // The response register lets a finished result wait for the sink while
    // the next request is accepted and worked on; the result step of that
    // request holds until the register is free.
    htlp_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key         (i_req.key),
        .i_age_in      (i_req.age_in),
        .i_read_slot   (i_req.read_slot),
        .i_out_ready   (o_rsp.ready),
        .o_status      (dp_status),
        .o_out_valid   (o_rsp.valid),
        .o_status_code (o_rsp.status),
        .o_slot_index  (o_rsp.slot_index),
        .o_key_out     (o_rsp.key_out),
        .o_age_out     (o_rsp.age_out)
    );

endmodule

// ===== hw/rtl/htlp_ctrl.sv =====
// Controller state machine of the hash table: sequences the clearing pass,
// hashing, probing, reads and result hand-off. Depends on htlp_pkg.
module htlp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_type,
    input  htlp_pkg::t_dp_status  i_status,
    output logic                  o_req_ready,
    output htlp_pkg::t_ctl_cmd    o_cmd
);
    import htlp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_type == REQ_READ) begin
                        n_state = S_READ_ISSUE;
                    end else if (i_status.full) begin
                        n_state = S_FULL;
                    end else begin
                        n_state = S_HASH_MUL;
                    end
                end
            end
            S_HASH_MUL:    n_state = S_HASH_SUB;
            S_HASH_SUB:    n_state = S_PROBE_START;
            S_PROBE_START: n_state = S_PROBE;
            S_PROBE: begin
                if (i_status.slot_free && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ_ISSUE:  n_state = S_READ_DONE;
            S_READ_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:       n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_HASH_MUL, S_HASH_SUB: begin
                o_cmd = '0;
            end
            S_PROBE_START: begin
                o_cmd.probe_start = 1'b1;
            end
            S_PROBE: begin
                // A taken slot moves on; a free one is written once the output is free.
                if (!i_status.slot_free) begin
                    o_cmd.probe_step = 1'b1;
                end else begin
                    o_cmd.probe_place = i_status.out_free;
                end
            end
            S_READ_ISSUE: begin
                o_cmd.read_issue = 1'b1;
            end
            S_READ_DONE: begin
                o_cmd.read_done = i_status.out_free;
            end
            S_FULL: begin
                o_cmd.report_full = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/htlp_datapath.sv =====
// Datapath of the hash table: slot memory, occupancy count, modulo hash,
// probe address registers and the response register. Depends on htlp_pkg.
module htlp_datapath #(
    parameter int TABLE_SIZE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htlp_pkg::t_ctl_cmd            i_cmd,
    input  logic [htlp_pkg::KEY_W-1:0]    i_key,
    input  logic [htlp_pkg::AGE_W-1:0]    i_age_in,
    input  logic [htlp_pkg::SLOT_W-1:0]   i_read_slot,
    input  logic                          i_out_ready,
    output htlp_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    output logic [htlp_pkg::STATUS_W-1:0] o_status_code,
    output logic [htlp_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [htlp_pkg::KEY_W-1:0]    o_key_out,
    output logic [htlp_pkg::AGE_W-1:0]    o_age_out
);
    import htlp_pkg::*;

    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int CW     = $clog2(TABLE_SIZE + 1);
    localparam int EW     = AW + 8;
    localparam int PROD_W = KEY_W + RECIP_SHIFT;
    localparam int QW     = KEY_W + AW + 1;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((1 << RECIP_SHIFT) / TABLE_SIZE);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] addr);
        if (addr == AW'(TABLE_SIZE - 1)) begin
            return '0;
        end
        return addr + AW'(1);
    endfunction

    t_entry r_mem [TABLE_SIZE];
    t_entry r_rd_data;

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_clr_addr;
    logic [KEY_W-1:0]  r_key;
    logic [AGE_W-1:0]  r_age;
    logic [SLOT_W-1:0] r_read_slot;
    logic [PROD_W-1:0] r_prod;
    logic [AW:0]       r_rem;
    logic [AW-1:0]     r_chk_addr;
    logic [AW-1:0]     r_probe_addr;
    logic              r_first;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [KEY_W-1:0]    r_out_key;
    logic [AGE_W-1:0]    r_out_age;

    logic [KEY_W-1:0] quot;
    logic [QW-1:0]    quot_n;
    logic [QW-1:0]    rem_full;
    logic [AW:0]      rem_fix;
    logic [AW-1:0]    home;
    logic [EW-1:0]    rs_ext;
    logic [EW-1:0]    chk_ext;
    logic             rs_in_range;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             we;
    logic [AW-1:0]    wa;
    t_entry           wd;
    logic             out_free;

    // The quotient estimate is exact or one short, so one correction suffices.
    assign quot     = r_prod[PROD_W-1 -: KEY_W];
    assign quot_n   = QW'(quot) * QW'(TABLE_SIZE);
    assign rem_full = QW'(r_key) - quot_n;
    assign rem_fix  = (r_rem >= (AW+1)'(TABLE_SIZE)) ? r_rem - (AW+1)'(TABLE_SIZE) : r_rem;
    assign home     = rem_fix[AW-1:0];

    assign rs_ext      = EW'(r_read_slot);
    assign rs_in_range = rs_ext < EW'(TABLE_SIZE);
    assign chk_ext     = EW'(r_chk_addr);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        rd_en   = i_cmd.probe_start || i_cmd.probe_step || i_cmd.read_issue;
        rd_addr = rs_ext[AW-1:0];
        if (i_cmd.probe_start) begin
            rd_addr = home;
        end else if (i_cmd.probe_step) begin
            rd_addr = r_probe_addr;
        end
        we = i_cmd.clear || i_cmd.probe_place;
        wa = i_cmd.clear ? r_clr_addr : r_chk_addr;
        wd = '0;
        if (!i_cmd.clear) begin
            wd.valid = 1'b1;
            wd.key   = r_key;
            wd.age   = r_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_key;
            r_age       <= i_age_in;
            r_read_slot <= i_read_slot;
        end
        r_prod <= PROD_W'(r_key) * PROD_W'(RECIP);
        r_rem  <= rem_full[AW:0];
        if (i_cmd.probe_start) begin
            r_chk_addr   <= home;
            r_probe_addr <= wrap_inc(home);
            r_first      <= 1'b1;
        end else if (i_cmd.probe_step) begin
            r_chk_addr   <= r_probe_addr;
            r_probe_addr <= wrap_inc(r_probe_addr);
            r_first      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= wrap_inc(r_clr_addr);
            end
            if (i_cmd.probe_place) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.probe_place || i_cmd.read_done || i_cmd.report_full) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_place) begin
            r_out_status <= r_first ? STAT_HOME : STAT_PROBED;
            r_out_slot   <= chk_ext[SLOT_W-1:0];
            r_out_key    <= '0;
            r_out_age    <= '0;
        end else if (i_cmd.read_done) begin
            r_out_slot <= r_read_slot;
            if (rs_in_range && r_rd_data.valid) begin
                r_out_status <= STAT_OCCUPIED;
                r_out_key    <= r_rd_data.key;
                r_out_age    <= r_rd_data.age;
            end else begin
                r_out_status <= STAT_EMPTY;
                r_out_key    <= '0;
                r_out_age    <= '0;
            end
        end else if (i_cmd.report_full) begin
            r_out_status <= STAT_FULL;
            r_out_slot   <= '0;
            r_out_key    <= '0;
            r_out_age    <= '0;
        end
    end

    assign o_status.full      = (r_count == CW'(TABLE_SIZE));
    assign o_status.clr_last  = (r_clr_addr == AW'(TABLE_SIZE - 1));
    assign o_status.slot_free = !r_rd_data.valid;
    assign o_status.out_free  = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_status_code = r_out_status;
    assign o_slot_index  = r_out_slot;
    assign o_key_out     = r_out_key;
    assign o_age_out     = r_out_age;

endmodule
